FILE: rtl/mpfb_pkg.sv
// Shared definitions for the page-organized monochrome framebuffer engine.
// Command codes, panel stream bytes and the controller state encodings.
// No dependencies.
`timescale 1ns / 1ps

package mpfb_pkg;

	typedef enum logic [2:0] {
		CMD_FILL    = 3'd0,
		CMD_PIXEL   = 3'd1,
		CMD_ROW     = 3'd2,
		CMD_COLUMN  = 3'd3,
		CMD_REFRESH = 3'd4
	} cmd_t;

	localparam logic [7:0] BYTE_START_LINE = 8'h40;
	localparam logic [7:0] BYTE_PAGE_BASE  = 8'hB0;
	localparam logic [7:0] BYTE_COL_HIGH   = 8'h10;
	localparam logic [7:0] BYTE_COL_LOW    = 8'h00;
	localparam logic [7:0] BYTE_DISPLAY_ON = 8'hAF;
	localparam logic [7:0] BYTE_ALL_ON     = 8'hFF;
	localparam logic [7:0] BYTE_ALL_OFF    = 8'h00;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PIX  = 6'b000010,
		S_ROW  = 6'b000100,
		S_COL  = 6'b001000,
		S_FILL = 6'b010000,
		S_REF  = 6'b100000
	} state_t;

	// refresh stream phase
	typedef enum logic [2:0] {
		PH_START = 3'b001,
		PH_BODY  = 3'b010,
		PH_END   = 3'b100
	} phase_t;

endpackage

FILE: rtl/mono_page_framebuffer_engine_top.sv
// Page-organized monochrome framebuffer engine, top level.
// Depends on mpfb_pkg and mpfb_ram.
`timescale 1ns / 1ps

// One item is handled at a time; the frame store is a single-port-write,
// one-read RAM with registered read data, and every step below comes
// from that port. A refresh step is accepted, then the store read or the
// command byte lands in the output register once that register is free; a
// pixel is read, then written back. A row line reads the next byte while
// writing the current one. A column line and a fill write one byte per
// cycle. After reset a clearing pass over the whole store runs before the
// first item is accepted. Out-of-range draws and unused command codes
// finish in the accept cycle. The result register lets the next item
// enter while a refresh byte waits to be taken.
module mono_page_framebuffer_engine_top #(
	parameter int PANEL_WIDTH  = 128,
	parameter int PANEL_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // x[7:0], y[15:8], ink[16], zero
	input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
	output logic        m_axis_tuser,   // is_data
	output logic        m_axis_tlast    // last_of_frame
);

	localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = PAGE_COUNT * PANEL_WIDTH;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int PGW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int OFFW        = $clog2(PANEL_WIDTH + 3);
	localparam int CNTW        = $clog2(PANEL_WIDTH);

	mpfb_pkg::state_t state_q;
	mpfb_pkg::phase_t phase_q;

	logic [PGW-1:0]  page_q;
	logic [OFFW-1:0] off_q;
	logic [AW-1:0]   daddr_q;
	logic [AW-1:0]   line_addr_q;
	logic [CNTW-1:0] cnt_q;
	logic [7:0]      fill_val_q;
	logic [7:0]      mask_q;
	logic            on_q;
	logic [7:0]      ref_byte_q;
	logic            ref_mem_q;
	logic            ref_last_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_data_q;
	logic            out_last_q;

	logic [7:0]  in_x;
	logic [7:0]  in_y;
	logic        in_on;
	logic [2:0]  in_cmd;
	logic        acc;
	logic        x_ok;
	logic        y_ok;
	logic [AW-1:0] row_base;
	logic [AW-1:0] pix_idx;
	logic        out_free;
	logic        row_last;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic [7:0]    rmw_byte;

	assign in_x   = s_axis_tdata[7:0];
	assign in_y   = s_axis_tdata[15:8];
	assign in_on  = s_axis_tdata[16];
	assign in_cmd = s_axis_tuser;

	assign s_axis_tready = (state_q == mpfb_pkg::S_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign x_ok     = ({1'b0, in_x} < 9'(PANEL_WIDTH));
	assign y_ok     = ({1'b0, in_y} < 9'(PANEL_HEIGHT));
	assign row_base = AW'(int'(in_y[7:3]) * PANEL_WIDTH);
	assign pix_idx  = row_base + AW'(in_x);
	assign out_free = !out_valid_q || m_axis_tready;
	assign row_last = (cnt_q == CNTW'(PANEL_WIDTH - 1));

	assign rmw_byte = on_q ? (ram_rdata | mask_q) : (ram_rdata & ~mask_q);

	// store write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = line_addr_q;
		ram_wdata = fill_val_q;
		case (state_q)
			mpfb_pkg::S_PIX, mpfb_pkg::S_ROW: begin
				ram_we    = 1'b1;
				ram_wdata = rmw_byte;
			end
			mpfb_pkg::S_COL, mpfb_pkg::S_FILL: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// store read port
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = line_addr_q + AW'(1);
		if (acc) begin
			case (in_cmd)
				mpfb_pkg::CMD_PIXEL: begin
					ram_re    = x_ok && y_ok;
					ram_raddr = pix_idx;
				end
				mpfb_pkg::CMD_ROW: begin
					ram_re    = y_ok;
					ram_raddr = row_base;
				end
				mpfb_pkg::CMD_REFRESH: begin
					ram_re    = (phase_q == mpfb_pkg::PH_BODY) && (off_q >= OFFW'(3));
					ram_raddr = daddr_q;
				end
				default: begin
					ram_re = 1'b0;
				end
			endcase
		end else if (state_q == mpfb_pkg::S_ROW) begin
			ram_re = !row_last;
		end
	end

	mpfb_ram #(
		.DEPTH(STORE_BYTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control and refresh position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpfb_pkg::S_FILL;
			phase_q     <= mpfb_pkg::PH_START;
			page_q      <= '0;
			off_q       <= '0;
			daddr_q     <= '0;
			line_addr_q <= '0;
			cnt_q       <= '0;
			fill_val_q  <= mpfb_pkg::BYTE_ALL_OFF;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				mpfb_pkg::S_IDLE: begin
					if (acc) begin
						fill_val_q <= in_on ? mpfb_pkg::BYTE_ALL_ON : mpfb_pkg::BYTE_ALL_OFF;
						cnt_q      <= '0;
						case (in_cmd)
							mpfb_pkg::CMD_FILL: begin
								line_addr_q <= '0;
								state_q     <= mpfb_pkg::S_FILL;
							end
							mpfb_pkg::CMD_PIXEL: begin
								line_addr_q <= pix_idx;
								if (x_ok && y_ok) begin
									state_q <= mpfb_pkg::S_PIX;
								end
							end
							mpfb_pkg::CMD_ROW: begin
								line_addr_q <= row_base;
								if (y_ok) begin
									state_q <= mpfb_pkg::S_ROW;
								end
							end
							mpfb_pkg::CMD_COLUMN: begin
								line_addr_q <= AW'(in_x);
								if (x_ok) begin
									state_q <= mpfb_pkg::S_COL;
								end
							end
							mpfb_pkg::CMD_REFRESH: begin
								state_q <= mpfb_pkg::S_REF;
								case (phase_q)
									mpfb_pkg::PH_START: begin
										phase_q <= mpfb_pkg::PH_BODY;
										page_q  <= '0;
										off_q   <= '0;
										daddr_q <= '0;
									end
									mpfb_pkg::PH_BODY: begin
										if (off_q >= OFFW'(3)) begin
											daddr_q <= daddr_q + AW'(1);
										end
										if (off_q == OFFW'(PANEL_WIDTH + 2)) begin
											off_q <= '0;
											if (page_q == PGW'(PAGE_COUNT - 1)) begin
												phase_q <= mpfb_pkg::PH_END;
											end else begin
												page_q <= page_q + PGW'(1);
											end
										end else begin
											off_q <= off_q + OFFW'(1);
										end
									end
									default: begin
										phase_q <= mpfb_pkg::PH_START;
									end
								endcase
							end
							default: begin
								state_q <= mpfb_pkg::S_IDLE;
							end
						endcase
					end
				end
				mpfb_pkg::S_PIX: begin
					state_q <= mpfb_pkg::S_IDLE;
				end
				mpfb_pkg::S_ROW: begin
					line_addr_q <= line_addr_q + AW'(1);
					cnt_q       <= cnt_q + CNTW'(1);
					if (row_last) begin
						state_q <= mpfb_pkg::S_IDLE;
					end
				end
				mpfb_pkg::S_COL: begin
					line_addr_q <= line_addr_q + AW'(PANEL_WIDTH);
					cnt_q       <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(PAGE_COUNT - 1)) begin
						state_q <= mpfb_pkg::S_IDLE;
					end
				end
				mpfb_pkg::S_FILL: begin
					line_addr_q <= line_addr_q + AW'(1);
					if (line_addr_q == AW'(STORE_BYTES - 1)) begin
						state_q <= mpfb_pkg::S_IDLE;
					end
				end
				mpfb_pkg::S_REF: begin
					// hold until the output register can take the byte
					if (out_free) begin
						state_q <= mpfb_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= mpfb_pkg::S_IDLE;
				end
			endcase
			if (state_q == mpfb_pkg::S_REF && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			mask_q <= 8'(1) << in_y[2:0];
			on_q   <= in_on;
			case (phase_q)
				mpfb_pkg::PH_START: begin
					ref_byte_q <= mpfb_pkg::BYTE_START_LINE;
					ref_mem_q  <= 1'b0;
					ref_last_q <= 1'b0;
				end
				mpfb_pkg::PH_BODY: begin
					ref_last_q <= 1'b0;
					if (off_q == OFFW'(0)) begin
						ref_byte_q <= mpfb_pkg::BYTE_PAGE_BASE + 8'(page_q);
						ref_mem_q  <= 1'b0;
					end else if (off_q == OFFW'(1)) begin
						ref_byte_q <= mpfb_pkg::BYTE_COL_HIGH;
						ref_mem_q  <= 1'b0;
					end else if (off_q == OFFW'(2)) begin
						ref_byte_q <= mpfb_pkg::BYTE_COL_LOW;
						ref_mem_q  <= 1'b0;
					end else begin
						ref_byte_q <= mpfb_pkg::BYTE_COL_LOW;
						ref_mem_q  <= 1'b1;
					end
				end
				default: begin
					ref_byte_q <= mpfb_pkg::BYTE_DISPLAY_ON;
					ref_mem_q  <= 1'b0;
					ref_last_q <= 1'b1;
				end
			endcase
		end
		if (state_q == mpfb_pkg::S_REF && out_free) begin
			out_byte_q <= ref_mem_q ? ram_rdata : ref_byte_q;
			out_data_q <= ref_mem_q;
			out_last_q <= ref_last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_ref_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_cmd == mpfb_pkg::CMD_REFRESH) |=> state_q == mpfb_pkg::S_REF)
		else $error("refresh item did not enter the result stage");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mpfb_pkg::S_REF))
		else $error("result appeared without a refresh item");

	a_last_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(m_axis_tdata == mpfb_pkg::BYTE_DISPLAY_ON && !m_axis_tuser))
		else $error("end of frame on a byte other than display-on");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q != mpfb_pkg::S_IDLE && state_q != mpfb_pkg::S_REF)
		else $error("frame store written outside a drawing command");

endmodule

FILE: rtl/mpfb_ram.sv
// Frame store RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mpfb_ram #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [7:0]               wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [7:0]               rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: verif/testbench.sv
// Self-checking bench for mono_page_framebuffer_engine_top: directed rows, then random
// draw and refresh traffic, with every refresh byte checked against an in-bench predictor or a fixed expected byte.
// Depends on mpfb_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int W           = 128;
	localparam int H           = 64;
	localparam int PAGES       = (H + 7) / 8;
	localparam int STORE_BYTES = PAGES * W;
	localparam int SPAN        = W + 3;
	localparam int FRAME_LAST  = PAGES * SPAN + 1;
	localparam int RAND_ITEMS  = 624;
	localparam int LIMIT       = 20000;

	// codes the engine must ignore
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;

	localparam logic [7:0] XW = 8'(W);
	localparam logic [7:0] XM = 8'(W - 1);
	localparam logic [7:0] YH = 8'(H);
	localparam logic [7:0] YM = 8'(H - 1);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_data;
		logic       last;
	} stream_byte_t;

	typedef struct packed {
		logic [2:0]   cmd;
		logic [7:0]   x;
		logic [7:0]   y;
		logic         on;
		logic         typed;
		stream_byte_t want;
	} dir_row_t;

	localparam stream_byte_t NONE = '0;
	localparam int PLAN_LEN = 26;
	localparam dir_row_t PLAN [PLAN_LEN] = '{
		'{mpfb_pkg::CMD_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1,
			'{mpfb_pkg::BYTE_START_LINE, 1'b0, 1'b0}},
		'{mpfb_pkg::CMD_REFRESH, 8'd255, 8'd255, 1'b1, 1'b1,
			'{mpfb_pkg::BYTE_PAGE_BASE,  1'b0, 1'b0}},
		'{mpfb_pkg::CMD_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1,
			'{mpfb_pkg::BYTE_COL_HIGH,   1'b0, 1'b0}},
		'{mpfb_pkg::CMD_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1,
			'{mpfb_pkg::BYTE_COL_LOW,    1'b0, 1'b0}},
		'{mpfb_pkg::CMD_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1,
			'{mpfb_pkg::BYTE_ALL_OFF,    1'b1, 1'b0}},
		'{mpfb_pkg::CMD_PIXEL,   8'd1,   8'd0,   1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_REFRESH, 8'd0,   8'd0,   1'b0, 1'b0, NONE},
		'{mpfb_pkg::CMD_PIXEL,   XM,     YM,     1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_PIXEL,   XW,     8'd0,   1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_PIXEL,   8'd0,   YH,     1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_PIXEL,   8'd255, 8'd255, 1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_ROW,     8'd255, YM,     1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_ROW,     8'd0,   YH,     1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_ROW,     8'd0,   8'd255, 1'b0, 1'b0, NONE},
		'{mpfb_pkg::CMD_COLUMN,  XM,     8'd255, 1'b0, 1'b0, NONE},
		'{mpfb_pkg::CMD_COLUMN,  8'd255, 8'd0,   1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_COLUMN,  8'd0,   8'd0,   1'b1, 1'b0, NONE},
		'{CMD_SPARE_A,           8'd255, 8'd255, 1'b1, 1'b0, NONE},
		'{CMD_SPARE_B,           8'd0,   8'd0,   1'b0, 1'b0, NONE},
		'{CMD_SPARE_C,           8'd1,   8'd1,   1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_PIXEL,   8'd0,   8'd0,   1'b0, 1'b0, NONE},
		'{mpfb_pkg::CMD_FILL,    8'd0,   8'd0,   1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_REFRESH, 8'd0,   8'd0,   1'b0, 1'b1,
			'{mpfb_pkg::BYTE_ALL_ON,     1'b1, 1'b0}},
		'{mpfb_pkg::CMD_FILL,    8'd255, 8'd255, 1'b0, 1'b0, NONE},
		'{mpfb_pkg::CMD_ROW,     8'd0,   8'd0,   1'b1, 1'b0, NONE},
		'{mpfb_pkg::CMD_REFRESH, 8'd0,   8'd0,   1'b0, 1'b0, NONE}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // x[7:0], y[15:8], ink[16], zero
	logic [2:0]  s_axis_tuser;   // cmd[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // out_byte[7:0]
	logic        m_axis_tuser;   // is_data
	logic        m_axis_tlast;   // last_of_frame

	logic [7:0]   fb_model [STORE_BYTES];
	int           refresh_idx;
	stream_byte_t pending_bytes [$];
	int           errors = 0;
	int           idle_cycles = 0;
	bit           no_idle;

	mono_page_framebuffer_engine_top #(
		.PANEL_WIDTH (W),
		.PANEL_HEIGHT(H)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// Advances the framebuffer copy by one item; has_out marks a refresh byte.
	function automatic void predict_item(input logic [2:0] cmd, input logic [7:0] x,
			input logic [7:0] y, input logic on, output bit has_out,
			output stream_byte_t res);
		logic [7:0] mask;
		int base, k, page, off;
		has_out = 1'b0;
		res     = '0;
		mask    = 8'd1 << y[2:0];
		base    = int'(y[7:3]) * W;
		case (cmd)
			mpfb_pkg::CMD_FILL: begin
				for (int i = 0; i < STORE_BYTES; i++)
					fb_model[i] = on ? mpfb_pkg::BYTE_ALL_ON : mpfb_pkg::BYTE_ALL_OFF;
			end
			mpfb_pkg::CMD_PIXEL: begin
				if (int'(x) < W && int'(y) < H)
					fb_model[base + x] = on ? (fb_model[base + x] | mask)
						: (fb_model[base + x] & ~mask);
			end
			mpfb_pkg::CMD_ROW: begin
				if (int'(y) < H)
					for (int i = 0; i < W; i++)
						fb_model[base + i] = on ? (fb_model[base + i] | mask)
							: (fb_model[base + i] & ~mask);
			end
			mpfb_pkg::CMD_COLUMN: begin
				if (int'(x) < W)
					for (int p = 0; p < PAGES; p++)
						fb_model[p * W + x] = on ? mpfb_pkg::BYTE_ALL_ON
							: mpfb_pkg::BYTE_ALL_OFF;
			end
			mpfb_pkg::CMD_REFRESH: begin
				has_out = 1'b1;
				if (refresh_idx == 0) begin
					res = '{mpfb_pkg::BYTE_START_LINE, 1'b0, 1'b0};
					refresh_idx = 1;
				end else if (refresh_idx >= FRAME_LAST) begin
					res = '{mpfb_pkg::BYTE_DISPLAY_ON, 1'b0, 1'b1};
					refresh_idx = 0;
				end else begin
					k    = refresh_idx - 1;
					page = k / SPAN;
					off  = k % SPAN;
					case (off)
						0: res = '{mpfb_pkg::BYTE_PAGE_BASE + 8'(page), 1'b0, 1'b0};
						1: res = '{mpfb_pkg::BYTE_COL_HIGH, 1'b0, 1'b0};
						2: res = '{mpfb_pkg::BYTE_COL_LOW, 1'b0, 1'b0};
						default: res = '{fb_model[page * W + off - 3], 1'b1, 1'b0};
					endcase
					refresh_idx++;
				end
			end
			default: ;
		endcase
	endfunction

	// mostly no gap, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	// Called at a clock edge; returns at the edge where the item is accepted.
	task automatic send_item(input logic [2:0] cmd, input logic [7:0] x, input logic [7:0] y,
			input logic on, input logic typed, input stream_byte_t want);
		int gap;
		bit has_out;
		stream_byte_t res;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, on, y, x};
		s_axis_tuser  <= cmd;
		do @(posedge clk); while (!s_axis_tready);
		predict_item(cmd, x, y, on, has_out, res);
		if (has_out)
			pending_bytes.push_back(typed ? want : res);
	endtask

	// hold the sender off until every refresh byte has come back
	task automatic drain();
		if (pending_bytes.size() != 0) begin
			s_axis_tvalid <= 1'b0;
			while (pending_bytes.size() != 0)
				@(posedge clk);
		end
	endtask

	// receiver: random stalls, stretches of full rate when no_idle is set
	initial begin
		int n;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		stream_byte_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected byte, actual %h data %b last %b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				errors++;
			end else begin
				want = pending_bytes.pop_front();
				if (m_axis_tdata !== want.data_byte) begin
					$display("%0t: out_byte expected %h actual %h", $time,
						want.data_byte, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser !== want.is_data) begin
					$display("%0t: is_data expected %b actual %b", $time,
						want.is_data, m_axis_tuser);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: last_of_frame expected %b actual %b", $time,
						want.last, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	// covers the clearing pass after reset and a full fill with room to spare
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int n_rand;
		int r;
		logic [2:0] cmd;
		logic [7:0] x, y;
		logic on;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		refresh_idx   = 0;
		no_idle       = 1'b0;
		n_rand        = 0;
		for (int i = 0; i < STORE_BYTES; i++)
			fb_model[i] = 8'd0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++)
			send_item(PLAN[i].cmd, PLAN[i].x, PLAN[i].y, PLAN[i].on, PLAN[i].typed,
				PLAN[i].want);
		drain();

		// refresh-heavy, with draws mixed in
		while (n_rand < RAND_ITEMS) begin
			if (n_rand % 150 == 149)
				drain();
			no_idle = (n_rand % 300) >= 250;
			r  = $urandom_range(0, 99);
			on = 1'($urandom_range(0, 1));
			x  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, W - 1))
				: 8'($urandom_range(0, 255));
			y  = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, H - 1))
				: 8'($urandom_range(0, 255));
			if (r < 78)
				cmd = mpfb_pkg::CMD_REFRESH;
			else if (r < 88)
				cmd = mpfb_pkg::CMD_PIXEL;
			else if (r < 92)
				cmd = mpfb_pkg::CMD_ROW;
			else if (r < 96)
				cmd = mpfb_pkg::CMD_COLUMN;
			else if (r < 97)
				cmd = mpfb_pkg::CMD_FILL;
			else
				cmd = 3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
			send_item(cmd, x, y, on, 1'b0, NONE);
			n_rand++;
		end
		drain();
		s_axis_tvalid <= 1'b0;
		no_idle = 1'b0;
		repeat (STORE_BYTES + 32) @(posedge clk);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
